>>> sv/str_pkg.sv
package str_pkg;

  localparam int FREQ_WIDTH     = 16;
  localparam int HOLD_IN_WIDTH  = 24;
  localparam int OUT_WIDTH      = 16;
  localparam int RAMP_WIDTH     = 8;
  localparam int DIVIDEND_WIDTH = 20;

  localparam logic [DIVIDEND_WIDTH-1:0] TIMER_CLOCK     = 20'd1000000;
  localparam logic [RAMP_WIDTH-1:0]     RAMP_STEP_RESET = 8'd10;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_ACCEL = 2'd1;
  localparam logic [1:0] PHASE_HOLD  = 2'd2;
  localparam logic [1:0] PHASE_DECEL = 2'd3;

  typedef struct packed {
    logic                     cmd;
    logic                     motor_select;
    logic                     direction;
    logic [FREQ_WIDTH-1:0]    low_freq_hz;
    logic [FREQ_WIDTH-1:0]    high_freq_hz;
    logic [HOLD_IN_WIDTH-1:0] hold_ticks;
  } str_in_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] period_now;
    logic [OUT_WIDTH-1:0] duty_first;
    logic [OUT_WIDTH-1:0] duty_second;
    logic                 dir_first;
    logic                 dir_second;
    logic [1:0]           phase;
    logic                 running;
    logic                 finished;
    logic                 rejected;
  } str_out_t;

endpackage

>>> sv/str_divider.sv
module str_divider
  import str_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [FREQ_WIDTH-1:0]     divisor_i,
  output logic                      done_o,
  output logic [DIVIDEND_WIDTH-1:0] quot_o
);

  localparam int CNT_W = $clog2(DIVIDEND_WIDTH);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVIDEND_WIDTH - 1);

  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [FREQ_WIDTH-1:0]     div_q, div_d;
  logic [FREQ_WIDTH-1:0]     rem_q, rem_d;
  logic [DIVIDEND_WIDTH-1:0] quot_q, quot_d;
  logic [FREQ_WIDTH:0]       rem_sh;
  logic [FREQ_WIDTH:0]       rem_sub;
  logic                      fits;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    rem_sh  = {rem_q, quot_q[DIVIDEND_WIDTH-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    fits    = rem_sh >= {1'b0, div_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      quot_d = TIMER_CLOCK;
    end else if (run_q) begin
      rem_d  = fits ? rem_sub[FREQ_WIDTH-1:0] : rem_sh[FREQ_WIDTH-1:0];
      quot_d = {quot_q[DIVIDEND_WIDTH-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LAST_CNT) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/stepper_trapezoid_ramp.sv
// Trapezoidal speed ramp for one of two stepper motors.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one beat per command:
// a start beat sets up a move, a tick beat advances the running move by one step.
// Output channel (out_valid_o/out_ready_i/out_data_o) gives exactly one result
// beat per input beat, in order.
// The configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the ramp
// step; it is always ready and should be written only while the block is idle.
// A tick or a rejected start goes straight to the emit state, which loads its
// result into the output register once that register is free. An accepted start
// first runs two bit-serial divisions in one shared divider, for the start and the
// floor period, and then emits its result. A new beat is accepted only after the
// previous result has entered the output register. The divider produces one quotient bit per cycle.
// The result sits in an output register, so the next beat is accepted while a
// result still waits; a result that cannot leave holds further processing.
// After reset the ramp is idle, all periods, duties and pins are 0 and the ramp
// step is 10.
module stepper_trapezoid_ramp
  import str_pkg::*;
#(
  parameter int PERIOD_WIDTH = 16,
  parameter int HOLD_WIDTH   = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  str_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output str_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [RAMP_WIDTH-1:0] cfg_data_i
);

  localparam int PW = PERIOD_WIDTH;
  localparam int XW = (PW > DIVIDEND_WIDTH) ? PW : DIVIDEND_WIDTH;
  localparam logic [PW-1:0] PMASK = {PW{1'b1}};

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV_LO = 2'd1;
  localparam logic [1:0] ST_DIV_HI = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [RAMP_WIDTH-1:0]     ramp_q, ramp_d;
  logic [PW-1:0]             period_q, period_d;
  logic [PW-1:0]             floor_q, floor_d;
  logic [PW-1:0]             start_q, start_d;
  logic [HOLD_WIDTH-1:0]     hold_q, hold_d;
  logic                      busy_q, busy_d;
  logic                      motor_q, motor_d;
  logic [1:0]                dir_q, dir_d;
  logic [OUT_WIDTH-1:0]      duty0_q, duty0_d;
  logic [OUT_WIDTH-1:0]      duty1_q, duty1_d;
  logic [1:0]                phase_q, phase_d;
  logic                      fin_q, fin_d;
  logic                      rej_q, rej_d;
  logic                      lo_zero_q, lo_zero_d;
  logic [FREQ_WIDTH-1:0]     hi_freq_q, hi_freq_d;
  logic                      out_valid_q, out_valid_d;
  str_out_t                  out_q, out_d;

  logic                      in_acc;
  logic                      out_free;
  logic                      div_start;
  logic [FREQ_WIDTH-1:0]     div_divisor;
  logic                      div_done;
  logic [DIVIDEND_WIDTH-1:0] div_quot;
  logic [XW-1:0]             quot_x;
  logic [PW-1:0]             quot_sat;
  logic                      quot_zero_div;
  logic [PW-1:0]             new_period;
  logic [PW:0]               sum;
  logic [OUT_WIDTH-1:0]      new_duty;

  str_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign div_divisor = (state_q == ST_IDLE) ? in_data_i.low_freq_hz : hi_freq_q;
  assign div_start   = (in_acc && (in_data_i.cmd == CMD_START) && !busy_q) ||
                       ((state_q == ST_DIV_LO) && div_done);

  assign quot_zero_div = (state_q == ST_DIV_LO) ? lo_zero_q : (hi_freq_q == '0);
  assign quot_x        = XW'(div_quot);

  always_comb begin
    if (quot_zero_div || (quot_x > XW'(PMASK))) begin
      quot_sat = PMASK;
    end else begin
      quot_sat = PW'(quot_x);
    end
  end

  always_comb begin
    ramp_d      = cfg_valid_i ? cfg_data_i : ramp_q;
    state_d     = state_q;
    period_d    = period_q;
    floor_d     = floor_q;
    start_d     = start_q;
    hold_d      = hold_q;
    busy_d      = busy_q;
    motor_d     = motor_q;
    dir_d       = dir_q;
    duty0_d     = duty0_q;
    duty1_d     = duty1_q;
    phase_d     = phase_q;
    fin_d       = fin_q;
    rej_d       = rej_q;
    lo_zero_d   = lo_zero_q;
    hi_freq_d   = hi_freq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    new_period  = period_q;
    sum         = {1'b0, period_q} + (PW+1)'(ramp_q);
    new_duty    = OUT_WIDTH'(period_q >> 1);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          fin_d   = 1'b0;
          rej_d   = 1'b0;
          state_d = ST_EMIT;
          if (in_data_i.cmd == CMD_START) begin
            if (busy_q) begin
              rej_d = 1'b1;
            end else begin
              motor_d   = in_data_i.motor_select;
              lo_zero_d = (in_data_i.low_freq_hz == '0);
              hi_freq_d = in_data_i.high_freq_hz;
              hold_d    = HOLD_WIDTH'(in_data_i.hold_ticks);
              if (in_data_i.motor_select) begin
                dir_d[1] = in_data_i.direction;
              end else begin
                dir_d[0] = in_data_i.direction;
              end
              state_d = ST_DIV_LO;
            end
          end else if (busy_q) begin
            if ((period_q <= floor_q) && (hold_q != '0)) begin
              hold_d  = hold_q - 1'b1;
              phase_d = PHASE_HOLD;
            end else if (hold_q != '0) begin
              new_period = (period_q > PW'(ramp_q)) ? (period_q - PW'(ramp_q)) : '0;
              new_duty   = OUT_WIDTH'(new_period >> 1);
              period_d   = new_period;
              phase_d    = PHASE_ACCEL;
            end else if ((period_q <= start_q) && (period_q != PMASK)) begin
              new_period = sum[PW] ? PMASK : sum[PW-1:0];
              new_duty   = OUT_WIDTH'(new_period >> 1);
              period_d   = new_period;
              phase_d    = PHASE_DECEL;
            end else begin
              new_duty = '0;
              busy_d   = 1'b0;
              phase_d  = PHASE_IDLE;
              fin_d    = 1'b1;
            end
            if (phase_d != PHASE_HOLD) begin
              if (motor_q) begin
                duty1_d = new_duty;
              end else begin
                duty0_d = new_duty;
              end
            end
          end
        end
      end
      ST_DIV_LO: begin
        if (div_done) begin
          start_d = quot_sat;
          state_d = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        if (div_done) begin
          floor_d  = quot_sat;
          period_d = start_q;
          new_duty = OUT_WIDTH'(start_q >> 1);
          if (motor_q) begin
            duty1_d = new_duty;
            duty0_d = '0;
          end else begin
            duty0_d = new_duty;
            duty1_d = '0;
          end
          busy_d  = 1'b1;
          phase_d = PHASE_ACCEL;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.period_now  = OUT_WIDTH'(period_q);
          out_d.duty_first  = duty0_q;
          out_d.duty_second = duty1_q;
          out_d.dir_first   = dir_q[0];
          out_d.dir_second  = dir_q[1];
          out_d.phase       = phase_q;
          out_d.running     = busy_q;
          out_d.finished    = fin_q;
          out_d.rejected    = rej_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ramp_q      <= RAMP_STEP_RESET;
      period_q    <= '0;
      floor_q     <= '0;
      start_q     <= '0;
      hold_q      <= '0;
      busy_q      <= 1'b0;
      motor_q     <= 1'b0;
      dir_q       <= '0;
      duty0_q     <= '0;
      duty1_q     <= '0;
      phase_q     <= PHASE_IDLE;
      fin_q       <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ramp_q      <= ramp_d;
      period_q    <= period_d;
      floor_q     <= floor_d;
      start_q     <= start_d;
      hold_q      <= hold_d;
      busy_q      <= busy_d;
      motor_q     <= motor_d;
      dir_q       <= dir_d;
      duty0_q     <= duty0_d;
      duty1_q     <= duty1_d;
      phase_q     <= phase_d;
      fin_q       <= fin_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_zero_q <= lo_zero_d;
    hi_freq_q <= hi_freq_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
